@@ design/tfn_pkg.sv @@
// Shared types, widths and codes for the triangle face normal block.
package tfn_pkg;

    // Table depth; slots are taken modulo the depth, which must be a power of two.
    localparam int VERTEX_DEPTH = 256;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);

    localparam int SLOT_W  = 8;
    localparam int COORD_W = 16;
    localparam int E_W     = COORD_W + 1;   // edge component
    localparam int P_W     = 2 * E_W;       // edge product
    localparam int C_W     = P_W + 1;       // cross product component
    localparam int M_W     = P_W;           // cross product magnitude
    localparam int H_W     = M_W / 2;       // half of a magnitude for the split square
    localparam int SQ_W    = 2 * M_W;       // squared component
    localparam int L_W     = SQ_W + 2;      // squared length
    localparam int Q_W     = 15;            // unit component magnitude bits
    localparam int T_SHIFT = 28;            // scale of the target, two times Q1.14
    localparam int PP_W    = L_W + Q_W + 1; // running product length times quotient
    localparam int R_W     = PP_W + Q_W + 1; // remainder and step term
    localparam int N_W     = 16;

    localparam logic ACT_STORE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [N_W-1:0]     t_norm;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vertex;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] vertex_slot;
        t_coord            coord_x;
        t_coord            coord_y;
        t_coord            coord_z;
        logic [SLOT_W-1:0] corner_a;
        logic [SLOT_W-1:0] corner_b;
        logic [SLOT_W-1:0] corner_c;
    } t_cmd;

    typedef struct packed {
        t_norm normal_x;
        t_norm normal_y;
        t_norm normal_z;
        logic  degenerate;
    } t_res;

endpackage

@@ design/tfn_if.sv @@
// Valid/ready channel interfaces for commands and results.
interface tfn_cmd_if;
    logic          valid;
    logic          ready;
    tfn_pkg::t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfn_res_if;
    logic          valid;
    logic          ready;
    tfn_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/tfn_vtx_mem.sv @@
// Vertex table: three copies written together, each read at one corner address.
module tfn_vtx_mem (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  tfn_pkg::t_addr   i_waddr,
    input  tfn_pkg::t_vertex i_wdata,
    input  tfn_pkg::t_addr   i_raddr [3],
    output tfn_pkg::t_vertex o_rdata [3]
);
    import tfn_pkg::*;

    for (genvar k = 0; k < 3; k++) begin : g_copy
        t_vertex r_mem [VERTEX_DEPTH];
        t_vertex r_rd;

        always_ff @(posedge i_clk) begin
            if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
            if (i_en) begin
                r_rd <= r_mem[i_raddr[k]];
            end
        end

        assign o_rdata[k] = r_rd;
    end

endmodule

@@ design/tfn_cross.sv @@
// Edges, cross product, component squares and squared length over six stages.
module tfn_cross (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  tfn_pkg::t_vertex          i_v [3],
    output logic                      o_vld,
    output logic [tfn_pkg::SQ_W-1:0]  o_sq [3],
    output logic                      o_neg [3],
    output logic [tfn_pkg::L_W-1:0]   o_len2
);
    import tfn_pkg::*;

    t_coord v [3][3];

    logic                    r_vld [6];
    logic signed [E_W-1:0]   r_e1 [3];
    logic signed [E_W-1:0]   r_e2 [3];
    logic signed [P_W-1:0]   r_p  [6];
    logic signed [C_W-1:0]   r_c  [3];
    logic        [C_W-1:0]   w_mag_full [3];
    logic        [M_W-1:0]   w_mag [3];
    logic                    r_neg5 [3];
    logic        [2*H_W-1:0] r_hh [3];
    logic        [2*H_W-1:0] r_hl [3];
    logic        [2*H_W-1:0] r_ll [3];
    logic                    r_neg6 [3];
    logic        [SQ_W-1:0]  r_sq6 [3];
    logic                    r_neg7 [3];
    logic        [SQ_W-1:0]  r_sq7 [3];
    logic        [L_W-1:0]   r_len2;

    for (genvar k = 0; k < 3; k++) begin : g_unpack
        assign v[k][0] = i_v[k].x;
        assign v[k][1] = i_v[k].y;
        assign v[k][2] = i_v[k].z;
    end

    for (genvar i = 0; i < 3; i++) begin : g_mag
        assign w_mag_full[i] = r_c[i][C_W-1] ? C_W'(-r_c[i]) : C_W'(r_c[i]);
        assign w_mag[i]      = w_mag_full[i][M_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 6; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < 6; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= E_W'(v[1][i]) - E_W'(v[0][i]);
                r_e2[i] <= E_W'(v[2][i]) - E_W'(v[1][i]);
            end
            r_p[0] <= P_W'(r_e1[1]) * P_W'(r_e2[2]);
            r_p[1] <= P_W'(r_e1[2]) * P_W'(r_e2[1]);
            r_p[2] <= P_W'(r_e1[2]) * P_W'(r_e2[0]);
            r_p[3] <= P_W'(r_e1[0]) * P_W'(r_e2[2]);
            r_p[4] <= P_W'(r_e1[0]) * P_W'(r_e2[1]);
            r_p[5] <= P_W'(r_e1[1]) * P_W'(r_e2[0]);
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= C_W'(r_p[2*i]) - C_W'(r_p[2*i+1]);
            end
            // Squares are split into half-width partial products.
            for (int i = 0; i < 3; i++) begin
                r_neg5[i] <= r_c[i][C_W-1];
                r_hh[i]   <= w_mag[i][M_W-1:H_W] * w_mag[i][M_W-1:H_W];
                r_hl[i]   <= w_mag[i][M_W-1:H_W] * w_mag[i][H_W-1:0];
                r_ll[i]   <= w_mag[i][H_W-1:0]   * w_mag[i][H_W-1:0];
            end
            for (int i = 0; i < 3; i++) begin
                r_neg6[i] <= r_neg5[i];
                r_sq6[i]  <= (SQ_W'(r_hh[i]) << (2*H_W)) + (SQ_W'(r_hl[i]) << (H_W+1))
                           + SQ_W'(r_ll[i]);
            end
            for (int i = 0; i < 3; i++) begin
                r_neg7[i] <= r_neg6[i];
                r_sq7[i]  <= r_sq6[i];
            end
            r_len2 <= L_W'(r_sq6[0]) + L_W'(r_sq6[1]) + L_W'(r_sq6[2]);
        end
    end

    assign o_vld  = r_vld[5];
    assign o_sq   = r_sq7;
    assign o_neg  = r_neg7;
    assign o_len2 = r_len2;

endmodule

@@ design/tfn_norm.sv @@
// Exact truncated unit components: one quotient bit per stage in three lanes.
module tfn_norm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [tfn_pkg::SQ_W-1:0]  i_sq [3],
    input  logic                      i_neg [3],
    input  logic [tfn_pkg::L_W-1:0]   i_len2,
    output logic                      o_vld,
    output logic [tfn_pkg::Q_W-1:0]   o_q [3],
    output logic                      o_neg [3],
    output logic                      o_zero
);
    import tfn_pkg::*;

    // Each lane keeps rem = c^2 * 2^28 - q^2 * len2 and prod = q * len2,
    // so the test for a new bit needs only shifts and adds.
    logic             r_vld  [Q_W];
    logic             r_zero [Q_W];
    logic [L_W-1:0]   r_len  [Q_W];
    logic [R_W-1:0]   r_rem  [Q_W][3];
    logic [PP_W-1:0]  r_prod [Q_W][3];
    logic [Q_W-1:0]   r_q    [Q_W][3];
    logic             r_neg  [Q_W][3];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int B = Q_W - 1 - j;

        logic            vld_in;
        logic            zero_in;
        logic [L_W-1:0]  len_in;
        logic [R_W-1:0]  rem_in  [3];
        logic [PP_W-1:0] prod_in [3];
        logic [Q_W-1:0]  q_in    [3];
        logic            neg_in  [3];

        if (j == 0) begin : g_first
            assign vld_in  = i_vld;
            assign zero_in = (i_len2 == '0);
            assign len_in  = i_len2;
            for (genvar k = 0; k < 3; k++) begin : g_lane_in
                assign rem_in[k]  = R_W'(i_sq[k]) << T_SHIFT;
                assign prod_in[k] = '0;
                assign q_in[k]    = '0;
                assign neg_in[k]  = i_neg[k];
            end
        end else begin : g_next
            assign vld_in  = r_vld[j-1];
            assign zero_in = r_zero[j-1];
            assign len_in  = r_len[j-1];
            for (genvar k = 0; k < 3; k++) begin : g_lane_in
                assign rem_in[k]  = r_rem[j-1][k];
                assign prod_in[k] = r_prod[j-1][k];
                assign q_in[k]    = r_q[j-1][k];
                assign neg_in[k]  = r_neg[j-1][k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[j] <= zero_in;
                r_len[j]  <= len_in;
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic [R_W-1:0]  n_step;
            logic            n_take;

            always_comb begin
                n_step = ((R_W'(prod_in[k]) << 1) + (R_W'(len_in) << B)) << B;
                n_take = (rem_in[k] >= n_step);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_neg[j][k] <= neg_in[k];
                    if (n_take) begin
                        r_rem[j][k]  <= rem_in[k] - n_step;
                        r_prod[j][k] <= prod_in[k] + (PP_W'(len_in) << B);
                        r_q[j][k]    <= q_in[k] | (Q_W'(1) << B);
                    end else begin
                        r_rem[j][k]  <= rem_in[k];
                        r_prod[j][k] <= prod_in[k];
                        r_q[j][k]    <= q_in[k];
                    end
                end
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_zero = r_zero[Q_W-1];
    for (genvar k = 0; k < 3; k++) begin : g_out
        assign o_q[k]   = r_q[Q_W-1][k];
        assign o_neg[k] = r_neg[Q_W-1][k];
    end

endmodule

@@ design/triangle_face_normal_core.sv @@
// Top level of the triangle face normal block: vertex table and normal pipeline.
//
// The block takes command beats on i_cmd and gives result beats on o_res,
// both valid/ready channels; a beat moves at a clock edge with valid and
// ready high. A store beat (action low) writes coord_x/y/z into the vertex
// table at vertex_slot and gives no result. A compute beat (action high)
// reads the corners corner_a, corner_b and corner_c, forms both edges, their
// cross product and the unit normal in signed Q1.14, truncated toward zero.
// A cross product of zero length gives a zero normal with degenerate set.
// One beat is accepted every cycle while the output register is free or
// being read. A compute result passes through the table read at the
// accepting edge, the stages of edge, product and length arithmetic, the
// stages of exact normalization (one quotient bit per stage, three lanes
// side by side) and the output register.
// A store followed at once by a compute that reads the same slot sees the
// new vertex. When o_res.ready is low while a result waits, the whole
// pipeline holds and i_cmd.ready drops, so nothing is lost or repeated;
// bubbles in the pipeline do not hold up the output register being freed.
// Reset clears all valid bits; the table holds no defined contents until
// a slot is written, and reading an unwritten slot is not allowed.
module triangle_face_normal_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfn_cmd_if.sink    i_cmd,
    tfn_res_if.source  o_res
);
    import tfn_pkg::*;

    logic            w_en;
    logic            w_accept;
    t_addr           w_raddr [3];
    t_vertex         w_rd [3];
    logic            r_rd_vld;

    logic            w_x_vld;
    logic [SQ_W-1:0] w_x_sq [3];
    logic            w_x_neg [3];
    logic [L_W-1:0]  w_x_len2;

    logic            w_n_vld;
    logic [Q_W-1:0]  w_n_q [3];
    logic            w_n_neg [3];
    logic            w_n_zero;

    t_norm           n_norm [3];
    t_res            n_out;
    t_res            r_out;
    logic            r_out_vld;

    // The pipeline moves whenever the output register is free or being read.
    assign w_en        = !r_out_vld || o_res.ready;
    assign i_cmd.ready = w_en;
    assign w_accept    = i_cmd.valid && w_en;

    assign w_raddr[0] = t_addr'(i_cmd.data.corner_a);
    assign w_raddr[1] = t_addr'(i_cmd.data.corner_b);
    assign w_raddr[2] = t_addr'(i_cmd.data.corner_c);

    tfn_vtx_mem u_mem (
        .i_clk   (i_clk),
        .i_en    (w_accept),
        .i_we    (w_accept && (i_cmd.data.action == ACT_STORE)),
        .i_waddr (t_addr'(i_cmd.data.vertex_slot)),
        .i_wdata (t_vertex'{i_cmd.data.coord_x, i_cmd.data.coord_y, i_cmd.data.coord_z}),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // Only compute beats carry a valid bit down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (w_en) begin
            r_rd_vld <= w_accept && (i_cmd.data.action == ACT_COMPUTE);
        end
    end

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_rd_vld),
        .i_v     (w_rd),
        .o_vld   (w_x_vld),
        .o_sq    (w_x_sq),
        .o_neg   (w_x_neg),
        .o_len2  (w_x_len2)
    );

    tfn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_x_vld),
        .i_sq    (w_x_sq),
        .i_neg   (w_x_neg),
        .i_len2  (w_x_len2),
        .o_vld   (w_n_vld),
        .o_q     (w_n_q),
        .o_neg   (w_n_neg),
        .o_zero  (w_n_zero)
    );

    // Apply the sign of each cross component; a zero length forces zeros.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_n_zero) begin
                n_norm[k] = '0;
            end else if (w_n_neg[k]) begin
                n_norm[k] = -t_norm'(w_n_q[k]);
            end else begin
                n_norm[k] = t_norm'(w_n_q[k]);
            end
        end
        n_out.normal_x   = n_norm[0];
        n_out.normal_y   = n_norm[1];
        n_out.normal_z   = n_norm[2];
        n_out.degenerate = w_n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

endmodule
